FILE: sv/first_fit_block_allocator_assert.svh
// Assertion macros used by the allocator back end (ffba_back).
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Implication checked on every edge outside reset.
`define FFBA_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Implication checked in the cycle after the condition.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int POOL_W = 17;

    // Offsets are taken modulo 2^OFFSET_BITS.
    localparam int OFFSET_BITS = OFF_W;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  release_offset;
    } in_item_t;

    typedef struct packed {
        logic [OFF_W-1:0] granted_offset;
        logic             success;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic              is_release;
        logic              reject;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } cmd_t;

endpackage

FILE: sv/ffba_front.sv
// ----------------------------------------------------------------------------
// ffba_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ffba_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_pkg::in_item_t  in_data,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output ffba_pkg::cmd_t      cmd_data
);

    ffba_pkg::cmd_t q_reg [2];
    logic [1:0]     cnt_reg, cnt_next;
    logic           rd_reg, rd_next;
    logic           wr_reg, wr_next;
    ffba_pkg::cmd_t cls;
    logic           push, pop;

    always_comb
    begin
        cls.is_release = (in_data.kind == ffba_pkg::KIND_RELEASE);
        cls.reject     = (in_data.kind == ffba_pkg::KIND_ALLOC) &&
                         (in_data.request_size == '0);
        cls.size       = in_data.request_size;
        cls.offset     = in_data.release_offset;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

endmodule

FILE: sv/ffba_back.sv
// ----------------------------------------------------------------------------
// ffba_back
// Walks the block table for one command, then shifts entries to insert or
// remove a block when one is placed or released, and presents the result in an output register.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_assert.svh"

module ffba_back #(
    parameter int MAX_BLOCKS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffba_pkg::POOL_W-1:0]   pool_size,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ffba_pkg::cmd_t                cmd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ffba_pkg::out_item_t           out_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int END_W = ffba_pkg::SIZE_W + 1;
    localparam int OFFSET_BITS = ffba_pkg::OFFSET_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [ffba_pkg::OFF_W-1:0]  start_reg [MAX_BLOCKS];
    logic [ffba_pkg::SIZE_W-1:0] len_reg   [MAX_BLOCKS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic [END_W-1:0]  prev_end_reg;
    logic [END_W-1:0]  limit_reg;
    ffba_pkg::cmd_t    cmd_reg;
    logic              ins_reg;
    ffba_pkg::out_item_t res_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  ridx;
    logic [END_W-1:0]  s_ext, e_ext, need;
    logic              at_end, fit_here, fit_tail;
    logic [END_W-1:0]  pool_lim;
    logic [OFFSET_BITS-1:0] off_mask;

    assign ridx     = idx_reg[IDX_W-1:0];
    assign s_ext    = END_W'(start_reg[ridx]) & END_W'({OFFSET_BITS{1'b1}});
    assign e_ext    = s_ext + END_W'(len_reg[ridx]);
    assign need     = prev_end_reg + END_W'(cmd_reg.size);
    assign at_end   = (idx_reg == count_reg);
    assign fit_here = (s_ext >= prev_end_reg) && (need <= s_ext) && (need <= limit_reg);
    assign fit_tail = (need <= limit_reg);
    assign off_mask = '1;
    assign pool_lim = (END_W'(pool_size) > (END_W'(1) << OFFSET_BITS)) ?
                      (END_W'(1) << OFFSET_BITS) : END_W'(pool_size);

    assign cmd_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (cmd_valid && cmd_ready) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (cmd_reg.reject || (!cmd_reg.is_release &&
                    count_reg == CNT_W'(MAX_BLOCKS)))
                    state_next = ST_DONE;
                else if (cmd_reg.is_release)
                begin
                    if (at_end)
                        state_next = ST_DONE;
                    else if (start_reg[ridx][OFFSET_BITS-1:0] ==
                             cmd_reg.offset[OFFSET_BITS-1:0])
                        state_next = ST_SHIFT;
                end
                else if (at_end || fit_here)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (ins_reg ? (idx_reg == slot_reg) : (idx_reg + 1'b1 >= count_reg))
                    state_next = ST_DONE;
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            // Only a placed or removed block changes the count.
            if (state_reg == ST_SHIFT && state_next == ST_DONE && res_reg.success)
                count_reg <= ins_reg ? count_reg + 1'b1 : count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                // Hold the previous result until the next command is taken.
                if (cmd_valid && cmd_ready)
                begin
                    cmd_reg      <= cmd_data;
                    idx_reg      <= '0;
                    prev_end_reg <= '0;
                    limit_reg    <= pool_lim;
                    res_reg      <= '0;
                end
            end
            ST_SCAN:
            begin
                if (cmd_reg.is_release || cmd_reg.reject)
                begin
                    if (!at_end && !cmd_reg.reject)
                    begin
                        if (start_reg[ridx][OFFSET_BITS-1:0] ==
                            cmd_reg.offset[OFFSET_BITS-1:0])
                        begin
                            ins_reg         <= 1'b0;
                            res_reg.success <= 1'b1;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                else if (count_reg != CNT_W'(MAX_BLOCKS))
                begin
                    if ((at_end && fit_tail) || (!at_end && fit_here))
                    begin
                        ins_reg  <= 1'b1;
                        slot_reg <= idx_reg;
                        idx_reg  <= count_reg;
                        res_reg.success <= 1'b1;
                        res_reg.granted_offset <= ffba_pkg::OFF_W'(
                            prev_end_reg[OFFSET_BITS-1:0] & off_mask);
                    end
                    else if (at_end)
                    begin
                        ins_reg  <= 1'b1;
                        slot_reg <= count_reg;
                        idx_reg  <= count_reg;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (e_ext > prev_end_reg)
                            prev_end_reg <= e_ext;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (ins_reg)
                begin
                    if (res_reg.success)
                    begin
                        if (idx_reg == slot_reg)
                        begin
                            start_reg[ridx] <= ffba_pkg::OFF_W'(
                                prev_end_reg[OFFSET_BITS-1:0]);
                            len_reg[ridx]   <= cmd_reg.size;
                        end
                        else
                        begin
                            start_reg[ridx] <= start_reg[IDX_W'(idx_reg - 1'b1)];
                            len_reg[ridx]   <= len_reg[IDX_W'(idx_reg - 1'b1)];
                            idx_reg         <= idx_reg - 1'b1;
                        end
                    end
                end
                else if (idx_reg + 1'b1 < count_reg)
                begin
                    start_reg[ridx] <= start_reg[IDX_W'(idx_reg + 1'b1)];
                    len_reg[ridx]   <= len_reg[IDX_W'(idx_reg + 1'b1)];
                    idx_reg         <= idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    `FFBA_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS))
    `FFBA_ASSERT_IMPL(a_ready_idle, clk, rst_n, cmd_ready, state_reg == ST_IDLE)
    `FFBA_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == ST_DONE, out_valid_reg)

endmodule

FILE: sv/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a configurable pool with an address-ordered table.
// ----------------------------------------------------------------------------
// An allocate transaction takes the first gap from the pool base that holds
// request_size bytes and returns its offset; a release transaction removes
// the block whose start matches exactly. One transaction is processed at a
// time by the back end: it walks the table one entry per cycle until it finds
// the gap or the matching start, then shifts the entries past that slot one
// per cycle. The back end takes the next command only once the result of
// the last one has been handed out, so it never starts a new transaction
// before it is through with the last. A two-entry command queue lets the
// input side keep taking transactions while the back end works, and the
// result sits in an output register until taken. pool_size may only be
// written while no transaction is in flight.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ffba_pkg::POOL_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffba_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ffba_pkg::out_item_t         out_data
);

    // Pool size register; resets to the full 64 KiB pool.
    logic [ffba_pkg::POOL_W-1:0] pool_size_reg;

    logic           cmd_valid, cmd_ready;
    ffba_pkg::cmd_t cmd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_size_reg <= ffba_pkg::POOL_W'(65536);
        else if (cfg_we)
            pool_size_reg <= cfg_wdata;
    end

    // Front: accept and classify, hold in queue.
    ffba_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data)
    );

    // Back: walk and update the table, register the result.
    ffba_back #(
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_size (pool_size_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
